// File: hw/rtl/kbud_pkg.sv
// kbud_pkg: shared types and constants for the keyed block unshuffle decryptor
// no dependencies
`timescale 1ns / 1ps
package kbud_pkg;
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    localparam logic [1:0] STATUS_DATA  = 2'd0;
    localparam logic [1:0] STATUS_CLEAN = 2'd1;
    localparam logic [1:0] STATUS_TRUNC = 2'd2;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_ESCAPE   = 2'd2;
    localparam logic [1:0] REG_FILL     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_RANK,
        ST_EMIT,
        ST_OUT,
        ST_FLUSH
    } state_t;
endpackage

// File: hw/rtl/kbud_rank.sv
// kbud_rank: counts settled key values below a candidate (signed), one compare per step
// depends on kbud_pkg
`timescale 1ns / 1ps
module kbud_rank (
    input  logic       aclk,
    input  logic       clear,
    input  logic       step,
    input  logic [7:0] cand,
    input  logic [7:0] other,
    output logic [4:0] below,
    output logic       equal_seen
);
    import kbud_pkg::*;

    logic [4:0] below_reg;
    logic       equal_reg;

    always_ff @(posedge aclk) begin
        if (clear) begin
            below_reg <= '0;
            equal_reg <= 1'b0;
        end else if (step) begin
            if ($signed(other) < $signed(cand)) below_reg <= below_reg + 5'd1;
            if (other == cand) equal_reg <= 1'b1;
        end
    end

    assign below      = below_reg;
    assign equal_seen = equal_reg;
endmodule

// File: hw/rtl/keyed_block_unshuffle_decrypt.sv
// Keyed block unshuffle decryptor. Items arrive on the s_ channel and results
// leave on the m_ channel; configuration registers are written on the cfg_
// channel, and the user must write them only while the block is idle, which
// the block itself does not enforce. A ciphertext byte that does not complete
// a block, a restart and an ignored kind are each taken without leaving the
// idle state; an end item loads its status result and then holds the input
// until that result is taken. A byte that completes a block starts the decode
// on one shared comparator: key position i is settled by probe attempts that
// compare it with every lower position, one more attempt for every collision
// with a lower position; every position is then ranked against all settled
// values; each plain byte is then formed and filtered in ST_EMIT and passed on
// in ST_OUT, and a closing ST_FLUSH state marks the last result. A result the
// receiver does not take stalls the decode and the input.
// depends on kbud_pkg, kbud_rank
`timescale 1ns / 1ps
module keyed_block_unshuffle_decrypt #(
    parameter int BLOCK_BYTES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_cipher_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_plain_byte,
    output logic [1:0]  m_status,
    output logic        m_last_of_run,
    output logic [31:0] m_decrypted_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import kbud_pkg::*;

    localparam int IW = $clog2(BLOCK_BYTES);

    logic [63:0] key_low_reg, key_high_reg;
    logic [7:0]  escape_reg, fill_reg;
    logic [7:0]  key_reg [16];
    logic [7:0]  uniq_reg [BLOCK_BYTES];
    logic [IW-1:0] rank_reg [BLOCK_BYTES];
    logic [7:0]  store_mem [BLOCK_BYTES];
    logic [4:0]  fill_level_reg;
    logic        escape_pending_reg;
    logic [31:0] total_reg;
    state_t      state_reg, state_next;
    logic [IW-1:0] i_reg;
    logic [4:0]  j_reg;
    logic [9:0]  s_reg;
    logic [7:0]  cur_reg;
    logic [7:0]  out_byte_reg;
    logic [1:0]  out_status_reg;
    logic        out_last_reg;
    logic        out_valid_reg;
    logic        pend_valid_reg;
    logic [7:0]  pend_byte_reg;
    logic        hold_valid_reg;
    logic [7:0]  hold_byte_reg;

    logic        r_clear, r_step;
    logic [7:0]  r_cand, r_other;
    logic [4:0]  r_below;
    logic        r_equal;
    logic [7:0]  p_byte, k_byte;
    logic        is_last;
    logic [IW-1:0] rk;
    logic        slot_free;
    logic        out_load;
    logic [7:0]  out_byte_next;
    logic [1:0]  out_status_next;
    logic        out_last_next;

    kbud_rank u_rank (
        .aclk(aclk), .clear(r_clear), .step(r_step), .cand(r_cand),
        .other(r_other), .below(r_below), .equal_seen(r_equal)
    );

    assign s_ready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_plain_byte = out_byte_reg;
    assign m_status  = out_status_reg;
    assign m_last_of_run = out_last_reg;
    assign m_decrypted_count = total_reg;

    assign r_cand  = (state_reg == ST_PROBE) ? cur_reg : uniq_reg[i_reg];
    assign r_other = uniq_reg[j_reg[IW-1:0]];
    assign r_step  = (state_reg == ST_PROBE) ? (j_reg < 5'(i_reg))
                   : (state_reg == ST_RANK)  ? (j_reg < 5'(BLOCK_BYTES)) : 1'b0;
    assign r_clear = !r_step;

    assign rk     = r_below[IW-1:0];
    assign k_byte = key_reg[i_reg];
    assign p_byte = store_mem[rank_reg[i_reg]] ^ k_byte;
    assign is_last = (i_reg == IW'(BLOCK_BYTES - 1));
    assign slot_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        out_load = 1'b0;
        out_byte_next = hold_byte_reg;
        out_status_next = STATUS_DATA;
        out_last_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (s_valid && s_ready) begin
                if (s_kind == KIND_DATA && fill_level_reg == 5'(BLOCK_BYTES - 1))
                    state_next = ST_PROBE;
                if (s_kind == KIND_END) begin
                    out_load = 1'b1;
                    out_byte_next = 8'd0;
                    out_status_next = (fill_level_reg == 5'd0) ? STATUS_CLEAN
                                                               : STATUS_TRUNC;
                    out_last_next = 1'b1;
                end
            end
            ST_PROBE: if (j_reg == 5'(i_reg) && !r_equal && i_reg == IW'(BLOCK_BYTES - 1))
                          state_next = ST_RANK;
            ST_RANK:  if (j_reg == 5'(BLOCK_BYTES) && is_last) state_next = ST_EMIT;
            ST_EMIT:  state_next = ST_OUT;
            ST_OUT: if (slot_free) begin
                // a held byte goes out once a later byte of the block survives
                out_load = pend_valid_reg && hold_valid_reg;
                state_next = is_last ? ST_FLUSH : ST_EMIT;
            end
            ST_FLUSH: if (slot_free) begin
                out_load = hold_valid_reg;
                out_last_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            key_low_reg <= '0;
            key_high_reg <= '0;
            escape_reg <= 8'd27;
            fill_reg <= 8'd0;
            for (int k = 0; k < 16; k++) key_reg[k] <= 8'd0;
            fill_level_reg <= '0;
            escape_pending_reg <= 1'b0;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_KEY_LOW:  key_low_reg <= cfg_data;
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                    REG_ESCAPE:   escape_reg <= cfg_data[7:0];
                    REG_FILL:     fill_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                out_byte_reg <= out_byte_next;
                out_status_reg <= out_status_next;
                out_last_reg <= out_last_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    unique case (s_kind)
                        KIND_RESTART: begin
                            for (int k = 0; k < 8; k++) begin
                                key_reg[k]   <= key_low_reg[8*k +: 8];
                                key_reg[k+8] <= key_high_reg[8*k +: 8];
                            end
                            fill_level_reg <= '0;
                            escape_pending_reg <= 1'b0;
                            total_reg <= '0;
                        end
                        KIND_END: begin
                            fill_level_reg <= '0;
                        end
                        KIND_DATA: begin
                            store_mem[fill_level_reg[IW-1:0]] <= s_cipher_byte;
                            if (fill_level_reg == 5'(BLOCK_BYTES - 1)) begin
                                fill_level_reg <= '0;
                                i_reg <= '0;
                                j_reg <= '0;
                                s_reg <= 10'd1;
                                cur_reg <= key_reg[0];
                            end else begin
                                fill_level_reg <= fill_level_reg + 5'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_PROBE: begin
                    if (j_reg < 5'(i_reg)) begin
                        j_reg <= j_reg + 5'd1;
                    end else if (r_equal) begin
                        cur_reg <= s_reg[0] ? cur_reg + s_reg[7:0] : cur_reg - s_reg[7:0];
                        s_reg <= s_reg + 10'd1;
                        j_reg <= '0;
                    end else begin
                        uniq_reg[i_reg] <= cur_reg;
                        j_reg <= '0;
                        s_reg <= 10'd1;
                        if (!is_last) begin
                            i_reg <= i_reg + IW'(1);
                            cur_reg <= key_reg[i_reg + IW'(1)];
                        end else begin
                            i_reg <= '0;
                        end
                    end
                end
                ST_RANK: begin
                    if (j_reg < 5'(BLOCK_BYTES)) begin
                        j_reg <= j_reg + 5'd1;
                    end else begin
                        rank_reg[i_reg] <= rk;
                        j_reg <= '0;
                        i_reg <= is_last ? '0 : i_reg + IW'(1);
                        if (is_last) total_reg <= total_reg + 32'(BLOCK_BYTES);
                    end
                end
                ST_EMIT: begin
                    key_reg[i_reg] <= i_reg[0] ? ~(p_byte - k_byte) : ~(p_byte + k_byte);
                    pend_byte_reg <= p_byte;
                    if (escape_pending_reg) begin
                        pend_valid_reg <= 1'b1;
                        if (p_byte == fill_reg || p_byte != escape_reg)
                            escape_pending_reg <= 1'b0;
                    end else if (p_byte == escape_reg) begin
                        escape_pending_reg <= 1'b1;
                        pend_valid_reg <= 1'b0;
                    end else begin
                        pend_valid_reg <= (p_byte != fill_reg);
                    end
                end
                ST_OUT: if (slot_free) begin
                    if (pend_valid_reg) begin
                        hold_byte_reg <= pend_byte_reg;
                        hold_valid_reg <= 1'b1;
                    end
                    i_reg <= is_last ? '0 : i_reg + IW'(1);
                end
                ST_FLUSH: if (slot_free) hold_valid_reg <= 1'b0;
                default: ;
            endcase
        end
    end
endmodule
